@@ hdl/min_max_contrast_stretch_top_assert.svh @@
// Assertion macros used by the contrast stretch checker.
// Every macro samples on the rising edge of clock.
`ifndef MIN_MAX_CONTRAST_STRETCH_TOP_ASSERT_SVH
`define MIN_MAX_CONTRAST_STRETCH_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define MMCS_ASSERT_IMP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define MMCS_ASSERT_NXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define MMCS_ASSERT_NXT_ALWAYS(label, pre, post, msg) \
   label: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ hdl/mmcs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmcs_pkg
// Shared constants for the min/max contrast stretch block.
// ---------------------------------------------------------------------------
package mmcs_pkg;

   // Width of the gain register and of the stretched output sample.
   localparam int GAIN_BITS = 16;
   localparam int OUT_BITS  = 16;

   // Quotient bits are produced one per step; the step counter covers them.
   localparam int STEP_BITS = $clog2(OUT_BITS);

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd255;

   // Request kind carried in tuser bit 0.
   localparam logic KIND_MEASURE = 1'b0;
   localparam logic KIND_SCALE   = 1'b1;

endpackage

@@ hdl/mmcs_minmax.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmcs_minmax
// Running frame minimum and maximum, both starting from zero.
// ---------------------------------------------------------------------------
module mmcs_minmax
   import mmcs_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fold,
   input  logic                          frame_start,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [SAMPLE_BITS-1:0] minimum,
   output logic signed [SAMPLE_BITS-1:0] maximum
);

   logic signed [SAMPLE_BITS-1:0] min_ff;
   logic signed [SAMPLE_BITS-1:0] max_ff;
   logic signed [SAMPLE_BITS-1:0] min_base;
   logic signed [SAMPLE_BITS-1:0] max_base;
   logic signed [SAMPLE_BITS-1:0] min_in;
   logic signed [SAMPLE_BITS-1:0] max_in;

   // A frame start folds against zero instead of the old extremes.
   always_comb begin
      min_base = frame_start ? '0 : min_ff;
      max_base = frame_start ? '0 : max_ff;
      min_in   = (sample < min_base) ? sample : min_base;
      max_in   = (sample > max_base) ? sample : max_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= '0;
      end else if (fold) begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   assign minimum = min_ff;
   assign maximum = max_ff;

endmodule

@@ hdl/mmcs_divider.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmcs_divider
// Multiply by gain, then restoring division one quotient bit per cycle,
// saturating to the output width.
// ---------------------------------------------------------------------------
module mmcs_divider
   import mmcs_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SAMPLE_BITS-1:0] numerator,
   input  logic [SAMPLE_BITS-1:0] divisor,
   input  logic [GAIN_BITS-1:0]   gain,
   output logic                   done,
   output logic [OUT_BITS-1:0]    quotient
);

   localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_MUL,
      DIV_CHK,
      DIV_STEP
   } div_state_type;

   div_state_type          state_ff, state_in;
   logic                   done_ff, done_in;
   logic [SAMPLE_BITS-1:0] num_ff, num_in;
   logic [SAMPLE_BITS-1:0] div_ff, div_in;
   logic [GAIN_BITS-1:0]   gain_ff, gain_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [OUT_BITS-1:0]    low_ff, low_in;
   logic [OUT_BITS-1:0]    quot_ff, quot_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [SAMPLE_BITS:0]   trial;
   logic [SAMPLE_BITS:0]   diff;

   // Shift in the next product bit and try a subtract; the carry out decides.
   assign trial = {rem_ff, low_ff[OUT_BITS-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      num_in   = num_ff;
      div_in   = div_ff;
      gain_in  = gain_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               num_in   = numerator;
               div_in   = divisor;
               gain_in  = gain;
               state_in = DIV_MUL;
            end
         end
         DIV_MUL: begin
            prod_in  = PROD_BITS'(num_ff) * PROD_BITS'(gain_ff);
            state_in = DIV_CHK;
         end
         DIV_CHK: begin
            // Upper product half at or above the divisor: quotient overflows.
            if (prod_ff[PROD_BITS-1:OUT_BITS] >= div_ff) begin
               quot_in  = '1;
               done_in  = 1'b1;
               state_in = DIV_IDLE;
            end else begin
               rem_in   = prod_ff[PROD_BITS-1:OUT_BITS];
               low_in   = prod_ff[OUT_BITS-1:0];
               quot_in  = '0;
               step_in  = '1;
               state_in = DIV_STEP;
            end
         end
         DIV_STEP: begin
            rem_in  = diff[SAMPLE_BITS] ? trial[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
            quot_in = {quot_ff[OUT_BITS-2:0], ~diff[SAMPLE_BITS]};
            low_in  = {low_ff[OUT_BITS-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               done_in  = 1'b1;
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      num_ff  <= num_in;
      div_ff  <= div_in;
      gain_ff <= gain_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

@@ hdl/min_max_contrast_stretch_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// min_max_contrast_stretch_top
// Two-pass min/max contrast stretch over a frame of signed samples.
// ---------------------------------------------------------------------------
// Send a frame twice. First pass: measure requests (tuser kind = 0) fold each
// sample into a running minimum and maximum that start at zero, so the range
// always includes zero; set frame_start on the first measure request of a
// frame to clear both first. A measure request produces no response and
// leaves the block ready for the next request. Second pass: each scale
// request (kind = 1) produces one response floor((sample - min) * gain /
// (max - min)), clamped to 0..65535. When max equals min the response is 0
// with range_empty set. A scale request occupies the block from acceptance
// until the next request can be taken: it forms the range and offset, does
// the gain multiply and the overflow check, runs the restoring divider (one
// quotient bit per cycle through a single shared subtractor), and hands the
// result to the response register once that register is free. Requests
// whose result is known early (empty range, sample at or below the minimum)
// skip the divider; a quotient that overflows is caught at the check and
// saturates. The response register decouples the two sides: a new request
// is accepted while the previous response still waits for rsp_tready.
// Write the gain on the csr port only while no request is in flight.
// ---------------------------------------------------------------------------
module min_max_contrast_stretch_top
   import mmcs_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [REQ_DATA_BITS-1:0]    req_tdata,   // [SAMPLE_BITS-1:0] sample
   input  logic [1:0]                  req_tuser,   // [0] kind, [1] frame_start
   // Response channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [OUT_BITS-1:0]         rsp_tdata,   // [15:0] scaled_sample
   output logic                        rsp_tuser,   // [0] range_empty
   // Gain register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [GAIN_BITS-1:0]        csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_WAIT,
      ST_PUT
   } state_type;

   state_type                      state_ff, state_in;
   logic [GAIN_BITS-1:0]           gain_ff, gain_in;
   logic signed [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic [OUT_BITS-1:0]            result_ff, result_in;
   logic                           empty_ff, empty_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]            rsp_data_ff, rsp_data_in;
   logic                           rsp_empty_ff, rsp_empty_in;

   logic                           req_take;
   logic                           fold;
   logic signed [SAMPLE_BITS-1:0]  req_sample;
   logic signed [SAMPLE_BITS-1:0]  frame_min;
   logic signed [SAMPLE_BITS-1:0]  frame_max;
   logic [SAMPLE_BITS:0]           range_wide;
   logic [SAMPLE_BITS:0]           offset_wide;
   logic                           range_zero;
   logic                           offset_pos;
   logic                           div_start;
   logic                           div_done;
   logic [OUT_BITS-1:0]            div_quot;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign req_sample = req_tdata[SAMPLE_BITS-1:0];
   assign fold       = req_take && (req_tuser[0] == KIND_MEASURE);
   assign csr_ready  = 1'b1;

   mmcs_minmax #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_minmax (
      .clock       (clock),
      .reset       (reset),
      .fold        (fold),
      .frame_start (req_tuser[1]),
      .sample      (req_sample),
      .minimum     (frame_min),
      .maximum     (frame_max)
   );

   // Range is max - min, never negative since min <= 0 <= max; the offset
   // sample - min is one bit wider and may go negative.
   assign range_wide  = {frame_max[SAMPLE_BITS-1], frame_max}
                        - {frame_min[SAMPLE_BITS-1], frame_min};
   assign offset_wide = {sample_ff[SAMPLE_BITS-1], sample_ff}
                        - {frame_min[SAMPLE_BITS-1], frame_min};
   assign range_zero  = (range_wide == '0);
   assign offset_pos  = !offset_wide[SAMPLE_BITS] && (offset_wide != '0);
   assign div_start   = (state_ff == ST_PREP) && !range_zero && offset_pos;

   mmcs_divider #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (offset_wide[SAMPLE_BITS-1:0]),
      .divisor   (range_wide[SAMPLE_BITS-1:0]),
      .gain      (gain_ff),
      .done      (div_done),
      .quotient  (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      gain_in      = gain_ff;
      sample_in    = sample_ff;
      result_in    = result_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_empty_in = rsp_empty_ff;

      if (csr_valid) begin
         gain_in = csr_data;
      end

      // Drop the response once the sink has taken it.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // Measure requests are folded in place; hold scale samples.
            if (req_take && (req_tuser[0] == KIND_SCALE)) begin
               sample_in = req_sample;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            empty_in  = range_zero;
            result_in = '0;
            if (div_start) begin
               state_in = ST_WAIT;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_WAIT: begin
            if (div_done) begin
               result_in = div_quot;
               state_in  = ST_PUT;
            end
         end
         ST_PUT: begin
            // Advance into the response register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               rsp_empty_in = empty_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff    <= sample_in;
      result_ff    <= result_in;
      empty_ff     <= empty_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_empty_ff;

endmodule

@@ hdl/mmcs_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmcs_checker
// Port-level checks for the contrast stretch block, bound to the top level.
// ---------------------------------------------------------------------------
`include "min_max_contrast_stretch_top_assert.svh"

module mmcs_checker
   import mmcs_pkg::*;
#(
   parameter int REQ_DATA_BITS = 16
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [REQ_DATA_BITS-1:0] req_tdata,
   input logic [1:0]               req_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [OUT_BITS-1:0]      rsp_tdata,
   input logic                     rsp_tuser
);

   logic req_take;
   logic req_unused;

   assign req_take   = req_tvalid && req_tready;
   assign req_unused = ^req_tdata;

   `MMCS_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")
   `MMCS_ASSERT_IMP(a_empty_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "empty range with non-zero sample")
   `MMCS_ASSERT_NXT(a_scale_busy, req_take && (req_tuser[0] == KIND_SCALE), !req_tready, "scale request did not occupy the block")
   `MMCS_ASSERT_NXT(a_measure_free, req_take && (req_tuser[0] == KIND_MEASURE) && !req_unused || req_take && (req_tuser[0] == KIND_MEASURE) && req_unused, req_tready, "measure request stalled the block")
   `MMCS_ASSERT_NXT_ALWAYS(a_reset_empty, reset, !rsp_tvalid, "response valid after reset")

endmodule

bind min_max_contrast_stretch_top mmcs_checker #(
   .REQ_DATA_BITS (REQ_DATA_BITS)
) u_mmcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
